### hw/rtl/edge_detect_pixel_stream_core_defines.svh
// Assertion helpers for the checker file.
`ifndef EDGE_DETECT_PIXEL_STREAM_CORE_DEFINES_SVH
`define EDGE_DETECT_PIXEL_STREAM_CORE_DEFINES_SVH

// Same-cycle implication, disabled while rstn is low.
`define EDP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while rstn is low.
`define EDP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/edp_pkg.sv
package edp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_BLUR   = 32;

    localparam int CB  = $clog2(MAX_WIDTH);       // column index bits
    localparam int RB  = $clog2(MAX_HEIGHT);      // row index bits
    localparam int WB  = $clog2(MAX_WIDTH + 1);   // width value bits
    localparam int HB  = $clog2(MAX_HEIGHT + 1);  // height value bits
    localparam int PW  = (WB > HB) ? WB : HB;     // shared position bits
    localparam int KB  = $clog2(MAX_BLUR + 1);    // blur length bits
    localparam int SB  = 8 + KB;                  // window sum bits
    localparam int PB  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int LGB = $clog2((2 + MAX_BLUR) * MAX_WIDTH + MAX_BLUR + 1);
    localparam int DCW = $clog2(SB + 1);          // divider step counter bits

    localparam int NPTS  = 13;                    // blur samples around a pixel
    localparam int NGRAD = 5;                     // gradients per suppression

    localparam int GRAY_MUL   = 683;              // ~ 2048/3
    localparam int GRAY_SHIFT = 11;
    localparam int MAG_GAIN   = 3;
    localparam int PIX_MAX    = 255;

    typedef enum logic [1:0] {
        REG_WIDTH,
        REG_HEIGHT,
        REG_BLUR,
        REG_THRESH
    } reg_idx_t;

    typedef struct packed {
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [5:0]  blur_size;
        logic [7:0]  edge_threshold;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GRAY,
        ST_HB_SETUP,
        ST_HB_READ,
        ST_HB_DIV,
        ST_ADV,
        ST_CHK,
        ST_EM_SETUP,
        ST_VB_SETUP,
        ST_VB_READ,
        ST_VB_DIV,
        ST_GRAD,
        ST_SUPP,
        ST_FIN
    } state_t;

    // Sample k of the diamond around the output pixel: row offset.
    function automatic logic signed [2:0] pt_dy(input logic [3:0] k);
        logic signed [2:0] d;
        case (k)
            4'd1, 4'd9, 4'd10:  d = -3'sd1;
            4'd2, 4'd11, 4'd12: d = 3'sd1;
            4'd5:               d = -3'sd2;
            4'd6:               d = 3'sd2;
            default:            d = 3'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [2:0] pt_dx(input logic [3:0] k);
        logic signed [2:0] d;
        case (k)
            4'd3, 4'd9, 4'd11:  d = -3'sd1;
            4'd4, 4'd10, 4'd12: d = 3'sd1;
            4'd7:               d = -3'sd2;
            4'd8:               d = 3'sd2;
            default:            d = 3'sd0;
        endcase
        return d;
    endfunction

    // Neighbour j of gradient center g (centers are samples 0..4).
    function automatic logic [3:0] nbr(input logic [2:0] g, input logic [1:0] j);
        logic [15:0] row;
        case (g)
            3'd0:    row = {4'd4, 4'd3, 4'd2, 4'd1};
            3'd1:    row = {4'd10, 4'd9, 4'd0, 4'd5};
            3'd2:    row = {4'd12, 4'd11, 4'd6, 4'd0};
            3'd3:    row = {4'd0, 4'd7, 4'd11, 4'd9};
            3'd4:    row = {4'd8, 4'd0, 4'd12, 4'd10};
            default: row = '0;
        endcase
        return row[4*j +: 4];
    endfunction

endpackage

### hw/rtl/edp_div.sv
module edp_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [edp_pkg::SB-1:0] dividend,
    input  logic [edp_pkg::KB-1:0] divisor,
    output logic                  done,
    output logic [edp_pkg::SB-1:0] quotient
);
    import edp_pkg::*;

    logic [KB:0]    rem_reg, rem_next;
    logic [SB-1:0]  quo_reg, quo_next;
    logic [KB-1:0]  dvs_reg;
    logic [DCW-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [KB:0]    shifted;
    logic [KB+1:0]  diff;

    // one quotient bit per cycle, restoring
    always_comb begin
        shifted   = {rem_reg[KB-1:0], quo_reg[SB-1]};
        diff      = {1'b0, shifted} - {2'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = DCW'(SB);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = diff[KB+1] ? shifted : diff[KB:0];
            quo_next = {quo_reg[SB-2:0], ~diff[KB+1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hw/rtl/edp_core.sv
module edp_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  edp_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          in_command,
    input  logic [7:0]    in_red,
    input  logic [7:0]    in_green,
    input  logic [7:0]    in_blue,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          out_edge_res,
    output logic [7:0]    out_strength,
    output logic          out_frame_end
);
    import edp_pkg::*;

    state_t state_reg, state_next;

    // memories
    logic [7:0] gray_mem [0:MAX_WIDTH-1];
    logic [7:0] hb_mem   [0:(2**(RB+CB))-1];
    logic [7:0] gray_rd_reg, hb_rd_reg;

    // frame geometry and counters
    logic           active_reg;
    logic [WB-1:0]  cur_w_reg;
    logic [HB-1:0]  cur_h_reg;
    logic [KB-1:0]  half_reg, ahead_reg;
    logic [7:0]     thr_reg;
    logic [LGB-1:0] lag_reg;
    logic [CB-1:0]  in_col_reg;
    logic [HB-1:0]  in_row_reg;
    logic [PB-1:0]  recv_reg, opos_reg;
    logic [CB-1:0]  ox_reg;
    logic [RB-1:0]  oy_reg;

    // work registers
    logic [7:0]     gray_reg;
    logic [CB-1:0]  hx_reg, hx_end_reg, col_reg;
    logic [PW-1:0]  i_reg, hi_reg;
    logic [SB-1:0]  sum_reg;
    logic [KB-1:0]  cnt_reg;
    logic           idone_reg, rd_pend_reg;
    logic [3:0]     k_reg;
    logic [2:0]     g_reg;
    logic [7:0]     bval_reg [0:NPTS-1];
    logic           bin_reg  [0:NPTS-1];
    logic [7:0]     gval_reg [0:NGRAD-1];
    logic [7:0]     str_reg;

    // output register
    logic       out_valid_reg;
    logic       out_edge_reg, out_last_reg;
    logic [7:0] out_str_reg;

    // config clamp for a new frame, and the gray product of the input pixel
    logic [WB-1:0]     w_c;
    logic [HB-1:0]     h_c;
    logic [KB-1:0]     k_c, half_c, ahead_c;
    logic [KB+WB:0]    lag_a, lag_b, lag_full;
    logic [9:0]        rgb_sum;
    logic [19:0]       gray_prod;

    always_comb begin
        if (cfg.frame_width == '0)                w_c = WB'(1);
        else if (32'(cfg.frame_width) > MAX_WIDTH) w_c = WB'(MAX_WIDTH);
        else                                      w_c = WB'(cfg.frame_width);
        if (cfg.frame_height == '0)                 h_c = HB'(1);
        else if (32'(cfg.frame_height) > MAX_HEIGHT) h_c = HB'(MAX_HEIGHT);
        else                                        h_c = HB'(cfg.frame_height);
        if (cfg.blur_size == '0)                k_c = KB'(1);
        else if (32'(cfg.blur_size) > MAX_BLUR) k_c = KB'(MAX_BLUR);
        else                                    k_c = KB'(cfg.blur_size);
        half_c   = k_c >> 1;
        ahead_c  = k_c - KB'(1) - half_c;
        lag_a    = {{(WB+1){1'b0}}, ahead_c} + (KB+WB+1)'(2);
        lag_b    = {{(KB+1){1'b0}}, w_c};
        lag_full = lag_a * lag_b + {{(WB+1){1'b0}}, ahead_c};
        rgb_sum   = {2'b0, in_red} + {2'b0, in_green} + {2'b0, in_blue};
        gray_prod = {10'b0, rgb_sum} * 20'(GRAY_MUL);
    end

    // position helpers
    logic [WB-1:0] c_ext, a_w, w_m1;
    logic          c_ge_a, c_last;
    logic signed [2:0] dy_k, dx_k;
    logic signed [PW:0] py, px;
    logic          pt_in;
    logic [PW-1:0] rpos, rlim, r_lo, r_hi;
    logic [PW:0]   r_sum;
    logic          border;

    always_comb begin
        c_ext  = WB'(in_col_reg);
        a_w    = WB'(ahead_reg);
        w_m1   = cur_w_reg - WB'(1);
        c_ge_a = c_ext >= a_w;
        c_last = c_ext == w_m1;

        dy_k = pt_dy(k_reg);
        dx_k = pt_dx(k_reg);
        py = $signed({{(PW+1-RB){1'b0}}, oy_reg}) + $signed({{(PW-2){dy_k[2]}}, dy_k});
        px = $signed({{(PW+1-CB){1'b0}}, ox_reg}) + $signed({{(PW-2){dx_k[2]}}, dx_k});
        pt_in = !py[PW] && (py[PW-1:0] < PW'(cur_h_reg)) &&
                !px[PW] && (px[PW-1:0] < PW'(cur_w_reg));

        // clipped window along a row or a column
        if (state_reg == ST_HB_SETUP) begin
            rpos = PW'(hx_reg);
            rlim = PW'(cur_w_reg);
        end else begin
            rpos = py[PW-1:0];
            rlim = PW'(cur_h_reg);
        end
        r_lo  = (rpos >= PW'(half_reg)) ? rpos - PW'(half_reg) : '0;
        r_sum = {1'b0, rpos} + (PW+1)'(ahead_reg);
        r_hi  = (r_sum > {1'b0, rlim - PW'(1)}) ? rlim - PW'(1) : r_sum[PW-1:0];

        border = (oy_reg == '0) || (ox_reg == '0) ||
                 ((HB+1)'(oy_reg) + (HB+1)'(1) >= (HB+1)'(cur_h_reg)) ||
                 ((WB+1)'(ox_reg) + (WB+1)'(1) >= (WB+1)'(cur_w_reg));
    end

    // gradient of one center, then 3x with saturation
    logic [7:0]  gc, gn, ad;
    logic [9:0]  gsum;
    logic [11:0] g3;
    logic [7:0]  gsat;

    always_comb begin
        gc   = bval_reg[4'(g_reg)];
        gsum = '0;
        for (int j = 0; j < 4; j++) begin
            gn = bval_reg[nbr(g_reg, 2'(j))];
            ad = (gn > gc) ? gn - gc : gc - gn;
            if (bin_reg[nbr(g_reg, 2'(j))]) begin
                gsum = gsum + 10'(ad);
            end
        end
        g3   = 12'(gsum) * 12'(MAG_GAIN);
        gsat = (g3 > 12'(PIX_MAX)) ? 8'(PIX_MAX) : g3[7:0];
    end

    // divider shared by row and column blur
    logic          div_start, div_done;
    logic [SB-1:0] div_q;

    edp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    logic accept, in_full, out_load;
    logic rd_issue, rd_ret;
    logic [7:0] rd_data;
    logic emit_now;
    logic out_last_c;

    assign accept  = in_valid && in_ready;
    assign in_full = active_reg && (in_row_reg >= cur_h_reg);
    assign emit_now = {1'b0, recv_reg} > ({1'b0, opos_reg} + (PB+1)'(lag_reg));
    assign out_last_c = (WB'(ox_reg) == w_m1) && (HB'(oy_reg) == cur_h_reg - HB'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_command) state_next = in_full ? ST_EM_SETUP : ST_IDLE;
                    else            state_next = in_full ? ST_IDLE : ST_GRAY;
                end
            end
            ST_GRAY:     state_next = (c_ge_a || c_last) ? ST_HB_SETUP : ST_ADV;
            ST_HB_SETUP: state_next = ST_HB_READ;
            ST_HB_READ:  if (idone_reg && !rd_pend_reg) state_next = ST_HB_DIV;
            ST_HB_DIV: begin
                if (div_done) state_next = (hx_reg == hx_end_reg) ? ST_ADV : ST_HB_SETUP;
            end
            ST_ADV:      state_next = ST_CHK;
            ST_CHK:      state_next = emit_now ? ST_EM_SETUP : ST_IDLE;
            ST_EM_SETUP: state_next = border ? ST_FIN : ST_VB_SETUP;
            ST_VB_SETUP: begin
                if (pt_in)                          state_next = ST_VB_READ;
                else if (k_reg == 4'(NPTS - 1))     state_next = ST_GRAD;
            end
            ST_VB_READ:  if (idone_reg && !rd_pend_reg) state_next = ST_VB_DIV;
            ST_VB_DIV: begin
                if (div_done) state_next = (k_reg == 4'(NPTS - 1)) ? ST_GRAD : ST_VB_SETUP;
            end
            ST_GRAD:     if (g_reg == 3'(NGRAD - 1)) state_next = ST_SUPP;
            ST_SUPP:     state_next = ST_FIN;
            ST_FIN:      if (out_load) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        in_ready  = (state_reg == ST_IDLE);
        rd_issue  = ((state_reg == ST_HB_READ) || (state_reg == ST_VB_READ)) && !idone_reg;
        rd_ret    = rd_pend_reg;
        rd_data   = (state_reg == ST_HB_READ) ? gray_rd_reg : hb_rd_reg;
        div_start = ((state_reg == ST_HB_READ) || (state_reg == ST_VB_READ)) &&
                    idone_reg && !rd_pend_reg;
        out_load  = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);
    end

    // memories: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (state_reg == ST_GRAY) begin
            gray_mem[in_col_reg] <= gray_reg;
        end
        if (rd_issue && (state_reg == ST_HB_READ)) begin
            gray_rd_reg <= gray_mem[i_reg[CB-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_HB_DIV) && div_done) begin
            hb_mem[{in_row_reg[RB-1:0], hx_reg}] <= div_q[7:0];
        end
        if (rd_issue && (state_reg == ST_VB_READ)) begin
            hb_rd_reg <= hb_mem[{i_reg[RB-1:0], col_reg}];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            recv_reg      <= '0;
            opos_reg      <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_issue;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (accept && !in_command && !in_full && !active_reg) begin
                active_reg <= 1'b1;
                in_col_reg <= '0;
                in_row_reg <= '0;
                recv_reg   <= '0;
                opos_reg   <= '0;
                ox_reg     <= '0;
                oy_reg     <= '0;
            end
            if (state_reg == ST_ADV) begin
                recv_reg <= recv_reg + PB'(1);
                if (c_last) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + HB'(1);
                end else begin
                    in_col_reg <= in_col_reg + CB'(1);
                end
            end
            if (out_load) begin
                if (out_last_c) begin
                    active_reg <= 1'b0;
                    in_col_reg <= '0;
                    in_row_reg <= '0;
                    recv_reg   <= '0;
                    opos_reg   <= '0;
                    ox_reg     <= '0;
                    oy_reg     <= '0;
                end else begin
                    opos_reg <= opos_reg + PB'(1);
                    if (WB'(ox_reg) == w_m1) begin
                        ox_reg <= '0;
                        oy_reg <= oy_reg + RB'(1);
                    end else begin
                        ox_reg <= ox_reg + CB'(1);
                    end
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (rd_ret) begin
            sum_reg <= sum_reg + SB'(rd_data);
            cnt_reg <= cnt_reg + KB'(1);
        end
        if (rd_issue) begin
            if (i_reg == hi_reg) idone_reg <= 1'b1;
            else                 i_reg     <= i_reg + PW'(1);
        end
        case (state_reg)
            ST_IDLE: begin
                gray_reg <= gray_prod[GRAY_SHIFT +: 8];
                if (accept && !in_command && !active_reg) begin
                    cur_w_reg <= w_c;
                    cur_h_reg <= h_c;
                    half_reg  <= half_c;
                    ahead_reg <= ahead_c;
                    thr_reg   <= cfg.edge_threshold;
                    lag_reg   <= lag_full[LGB-1:0];
                end
            end
            ST_GRAY: begin
                hx_reg     <= c_ge_a ? CB'(c_ext - a_w) : '0;
                hx_end_reg <= c_last ? CB'(w_m1) : CB'(c_ext - a_w);
            end
            ST_HB_SETUP: begin
                i_reg     <= r_lo;
                hi_reg    <= r_hi;
                sum_reg   <= '0;
                cnt_reg   <= '0;
                idone_reg <= 1'b0;
            end
            ST_HB_DIV: begin
                if (div_done && (hx_reg != hx_end_reg)) hx_reg <= hx_reg + CB'(1);
            end
            ST_EM_SETUP: begin
                k_reg   <= '0;
                g_reg   <= '0;
                str_reg <= '0;
            end
            ST_VB_SETUP: begin
                bin_reg[k_reg] <= pt_in;
                col_reg   <= px[CB-1:0];
                i_reg     <= r_lo;
                hi_reg    <= r_hi;
                sum_reg   <= '0;
                cnt_reg   <= '0;
                idone_reg <= 1'b0;
                if (!pt_in && (k_reg != 4'(NPTS - 1))) k_reg <= k_reg + 4'd1;
            end
            ST_VB_DIV: begin
                if (div_done) begin
                    bval_reg[k_reg] <= div_q[7:0];
                    if (k_reg != 4'(NPTS - 1)) k_reg <= k_reg + 4'd1;
                end
            end
            ST_GRAD: begin
                gval_reg[g_reg] <= gsat;
                g_reg <= g_reg + 3'd1;
            end
            ST_SUPP: begin
                if (((gval_reg[0] > gval_reg[1]) && (gval_reg[0] >= gval_reg[2])) ||
                    ((gval_reg[0] > gval_reg[3]) && (gval_reg[0] >= gval_reg[4]))) begin
                    str_reg <= gval_reg[0];
                end else begin
                    str_reg <= '0;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    out_str_reg  <= str_reg;
                    out_edge_reg <= str_reg > thr_reg;
                    out_last_reg <= out_last_c;
                end
            end
            default: begin
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign out_edge_res  = out_edge_reg;
    assign out_strength  = out_str_reg;
    assign out_frame_end = out_last_reg;

endmodule

### hw/rtl/edge_detect_pixel_stream_core.sv
// Edge detector for an RGB pixel stream in raster order.
// Input words (s_*): tdata = {blue, green, red}, tuser = command. Command 0 is a
// pixel; command 1 is a drain word that pulls one pending output after the
// frame's last pixel. Output words (m_*): tdata = {strength, edge_res},
// tlast = frame_end on the frame's last output pixel.
// Geometry, blur length and threshold come from the APB registers at the first
// pixel of a frame and hold for the whole frame.
// Latency: output pixel o leaves once input pixel o + (2+A)*W + A has arrived,
// A = k-1-k/2; the frame tail leaves through drain words.
// Throughput: one word at a time. A pixel pays, for each row-blur column it
// completes, for window reads from the line RAM and the 14-step shared divider.
// A word that emits adds up to 13 column blurs of the same cost and 5 gradients.
// The shared divider and the single read port of each RAM set that cost.
// Reset (synchronous, aresetn low): registers to defaults, no frame active, no
// word pending. No clearing pass: line RAMs are only read where already written.
// A stalled receiver holds the output register; input words are still taken and
// worked on until one emits, and its result waits until the register frees.
module edge_detect_pixel_stream_core (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic        s_tuser,   // command[0]
    // edge output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // edge_res[0], strength[8:1], zero[15:9]
    output logic        m_tlast    // frame_end
);
    import edp_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;
    logic       edge_res;
    logic [7:0] strength;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // register file: to be written only while idle; the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width    <= 11'd640;
            cfg_reg.frame_height   <= 11'd480;
            cfg_reg.blur_size      <= 6'd10;
            cfg_reg.edge_threshold <= 8'd45;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WIDTH:  cfg_reg.frame_width    <= pwdata[10:0];
                REG_HEIGHT: cfg_reg.frame_height   <= pwdata[10:0];
                REG_BLUR:   cfg_reg.blur_size      <= pwdata[5:0];
                REG_THRESH: cfg_reg.edge_threshold <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIDTH:  prdata = {21'b0, cfg_reg.frame_width};
            REG_HEIGHT: prdata = {21'b0, cfg_reg.frame_height};
            REG_BLUR:   prdata = {26'b0, cfg_reg.blur_size};
            REG_THRESH: prdata = {24'b0, cfg_reg.edge_threshold};
            default:    prdata = '0;
        endcase
    end

    edp_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_command    (s_tuser),
        .in_red        (s_tdata[7:0]),
        .in_green      (s_tdata[15:8]),
        .in_blue       (s_tdata[23:16]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_edge_res  (edge_res),
        .out_strength  (strength),
        .out_frame_end (m_tlast)
    );

    assign m_tdata = {7'b0, strength, edge_res};

endmodule

### hw/rtl/edp_checker.sv
`include "edge_detect_pixel_stream_core_defines.svh"

module edp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);
    // stalled output word stays offered
    `EDP_ASSERT_NXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "valid dropped")
    // stalled output word keeps its payload
    `EDP_ASSERT_NXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "payload changed")
    // an edge flag needs a nonzero strength
    `EDP_ASSERT_NOW(a_edge_str, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[8:1] != 8'd0, "edge with zero strength")
    // reset empties the output register
    `EDP_ASSERT_NXT(a_rst_empty, aclk, 1'b1, !aresetn, !m_tvalid, "output valid after reset")

endmodule

bind edge_detect_pixel_stream_core edp_checker u_edp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### tb/edge_detect_pixel_stream_core_tb.sv
`timescale 1ns / 1ps

module edge_detect_pixel_stream_core_tb;
    import edp_pkg::*;

    localparam bit CMD_PIXEL    = 1'b0;
    localparam bit CMD_DRAIN    = 1'b1;
    localparam int IDLE_LIMIT   = 20000;  // watchdog: cycles with no word moving
    localparam int SETTLE_WAIT  = 2000;   // block may still chew on an ignored word
    localparam int HOLD_CYCLES  = 4000;   // long receiver hold-off

    typedef struct packed {
        logic       edge_res;
        logic [7:0] strength;
        logic       frame_end;
    } edge_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
    logic        s_tuser = 1'b0; // command[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // edge_res[0], strength[8:1], zero[15:9]
    logic        m_tlast;

    edge_detect_pixel_stream_core dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Edge predictor: its own copy of registers, line store and counters.
    // ------------------------------------------------------------------
    logic [10:0] reg_width = 11'd640;
    logic [10:0] reg_height = 11'd480;
    logic [5:0]  reg_blur = 6'd10;
    logic [7:0]  reg_thresh = 8'd45;

    bit [7:0] gray_row [0:MAX_WIDTH-1];
    bit [7:0] row_blurred [0:MAX_HEIGHT-1][0:MAX_WIDTH-1];
    int unsigned pix_col, pix_row, out_pos;
    bit          frame_busy;
    int unsigned fr_w, fr_h, fr_k, fr_back, fr_ahead, fr_thr, fr_lag;

    edge_word_t edge_queue[$];   // edge words still to come out

    int mismatches = 0;
    int words_sent = 0, pixels_sent = 0, words_seen = 0, edges_seen = 0, frames_done = 0;
    int idle_cycles = 0;
    bit burst_mode = 1'b0;     // sender offers back to back
    bit hold_request = 1'b0;

    function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void blur_row_at(int unsigned r, int unsigned x);
        int unsigned lo, hi, sum, n;
        lo = (x >= fr_back) ? x - fr_back : 0;
        hi = x + fr_ahead;
        sum = 0;
        n = 0;
        if (hi > fr_w - 1) hi = fr_w - 1;
        for (int unsigned i = lo; i <= hi; i++) begin
            sum += gray_row[i];
            n++;
        end
        row_blurred[r][x] = 8'(sum / n);
    endfunction

    function automatic int unsigned blur_at(int unsigned y, int unsigned x);
        int unsigned lo, hi, sum, n;
        lo = (y >= fr_back) ? y - fr_back : 0;
        hi = y + fr_ahead;
        sum = 0;
        n = 0;
        if (hi > fr_h - 1) hi = fr_h - 1;
        for (int unsigned i = lo; i <= hi; i++) begin
            sum += row_blurred[i][x];
            n++;
        end
        return sum / n;
    endfunction

    function automatic int unsigned absdiff(int unsigned a, int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int unsigned gradient_at(int unsigned y, int unsigned x);
        int unsigned c, m;
        c = blur_at(y, x);
        m = 0;
        if (y > 0) m += absdiff(blur_at(y - 1, x), c);
        if (x > 0) m += absdiff(blur_at(y, x - 1), c);
        if (y + 1 < fr_h) m += absdiff(blur_at(y + 1, x), c);
        if (x + 1 < fr_w) m += absdiff(blur_at(y, x + 1), c);
        m *= MAG_GAIN;
        return (m > PIX_MAX) ? PIX_MAX : m;
    endfunction

    function automatic int unsigned thinned_at(int unsigned y, int unsigned x);
        int unsigned s;
        bit vmax, hmax;
        if (y == 0 || x == 0 || y + 1 >= fr_h || x + 1 >= fr_w) return 0;
        s = gradient_at(y, x);
        vmax = s > gradient_at(y - 1, x) && s >= gradient_at(y + 1, x);
        hmax = s > gradient_at(y, x - 1) && s >= gradient_at(y, x + 1);
        return (vmax || hmax) ? s : 0;
    endfunction

    function automatic edge_word_t next_edge_word();
        edge_word_t w;
        int unsigned s;
        s = thinned_at(out_pos / fr_w, out_pos % fr_w);
        w.edge_res = (s > fr_thr);
        w.strength = s[7:0];
        w.frame_end = (out_pos == fr_w * fr_h - 1);
        out_pos++;
        if (w.frame_end) begin
            frame_busy = 1'b0;
            pix_col = 0;
            pix_row = 0;
            out_pos = 0;
        end
        return w;
    endfunction

    // Advance the predictor by one accepted input word.
    function automatic void predict_edges(bit cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned c, x;
        if (cmd == CMD_DRAIN) begin
            if (frame_busy && pix_row >= fr_h) edge_queue.push_back(next_edge_word());
            return;
        end
        if (frame_busy && pix_row >= fr_h) return;   // frame tail pending: pixel dropped
        if (!frame_busy) begin
            fr_w = clip(reg_width, 1, MAX_WIDTH);
            fr_h = clip(reg_height, 1, MAX_HEIGHT);
            fr_k = clip(reg_blur, 1, MAX_BLUR);
            fr_back = fr_k / 2;
            fr_ahead = fr_k - 1 - fr_back;
            fr_thr = reg_thresh;
            fr_lag = (2 + fr_ahead) * fr_w + fr_ahead;
            pix_col = 0;
            pix_row = 0;
            out_pos = 0;
            frame_busy = 1'b1;
        end
        c = pix_col;
        gray_row[c] = 8'((int'(r) + int'(g) + int'(b)) / 3);
        if (c >= fr_ahead) blur_row_at(pix_row, c - fr_ahead);
        if (c == fr_w - 1) begin
            x = (c + 1 >= fr_ahead) ? c + 1 - fr_ahead : 0;
            for (; x < fr_w; x++) blur_row_at(pix_row, x);
        end
        pix_col++;
        if (pix_col == fr_w) begin
            pix_col = 0;
            pix_row++;
        end
        if (pix_row * fr_w + pix_col > out_pos + fr_lag) edge_queue.push_back(next_edge_word());
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int p;
        if (burst_mode) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one word; valid stays high into the next call unless it idles first.
    task automatic send_word(bit cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {b, g, r};
        do @(posedge aclk); while (!s_tready);
        predict_edges(cmd, r, g, b);
        words_sent++;
        if (cmd == CMD_PIXEL) pixels_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (edge_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 4'(idx) << 2;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WIDTH:  reg_width = val[10:0];
            REG_HEIGHT: reg_height = val[10:0];
            REG_BLUR:   reg_blur = val[5:0];
            default:    reg_thresh = val[7:0];
        endcase
    endtask

    task automatic reg_check(reg_idx_t idx, logic [31:0] want);
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= 4'(idx) << 2;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("register %s: expected %0d got %0d", idx.name(), want, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_frame(int w, int h, int k, int thr);
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_BLUR, k);
        reg_write(REG_THRESH, thr);
    endtask

    // Pixel content: mode 0 noise, 1 blocks, 2 stripes, 3 extremes only.
    function automatic logic [23:0] pixel_for(int mode, int x, int y);
        logic [7:0] v;
        case (mode)
            0: return {8'($urandom), 8'($urandom), 8'($urandom)};
            1: v = (((x / 3) + (y / 2)) % 2) ? 8'd250 : 8'd5;
            2: v = (x % 4 < 2) ? 8'($urandom_range(200, 255)) : 8'($urandom_range(0, 40));
            default: return ($urandom_range(0, 1)) ? 24'hFFFFFF : 24'h000000;
        endcase
        return {v, v, v};
    endfunction

    // One whole frame at the current registers, then drains for the tail.
    // With noise set, stray drains land mid-frame and stray pixels in the tail.
    task automatic run_frame(int mode, bit noise);
        int n;
        logic [23:0] p;
        n = clip(reg_width, 1, MAX_WIDTH) * clip(reg_height, 1, MAX_HEIGHT);
        for (int i = 0; i < n; i++) begin
            if (noise && $urandom_range(0, 19) == 0) send_word(CMD_DRAIN, 8'($urandom), 0, 0);
            p = pixel_for(mode, pix_col, pix_row);
            send_word(CMD_PIXEL, p[7:0], p[15:8], p[23:16]);
        end
        while (frame_busy) begin
            if (noise && $urandom_range(0, 9) == 0) begin
                p = pixel_for(0, 0, 0);
                send_word(CMD_PIXEL, p[7:0], p[15:8], p[23:16]);
            end else begin
                send_word(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
        frames_done++;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_registers();
        reg_check(REG_WIDTH, 640);
        reg_check(REG_HEIGHT, 480);
        reg_check(REG_BLUR, 10);
        reg_check(REG_THRESH, 45);
        set_frame(32'hFFFF_FFFF, 32'h0000_0555, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        reg_check(REG_WIDTH, 11'h7FF);
        reg_check(REG_HEIGHT, 11'h555);
        reg_check(REG_BLUR, 6'h3F);
        reg_check(REG_THRESH, 8'hFF);
    endtask

    task automatic test_corner_frames();
        // drains with no frame open are dropped
        send_word(CMD_DRAIN, 8'hFF, 8'hFF, 8'hFF);
        send_word(CMD_DRAIN, 0, 0, 0);
        wait_drained();
        // zero geometry and zero blur count as one: single pixel frame
        set_frame(0, 0, 0, 0);
        send_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        while (frame_busy) send_word(CMD_DRAIN, 0, 0, 0);
        wait_drained();
        set_frame(1, 1, 1, 255);
        send_word(CMD_PIXEL, 0, 0, 0);
        while (frame_busy) send_word(CMD_DRAIN, 0, 0, 0);
        wait_drained();
        // hard edges, threshold zero, blur of one: every interior max is an edge
        set_frame(4, 4, 1, 0);
        run_frame(3, 1'b1);
        // oversized blur saturates at the maximum length
        set_frame(5, 3, 63, 10);
        run_frame(1, 1'b0);
        set_frame(3, 5, 2, 1);
        run_frame(2, 1'b1);
    endtask

    task automatic test_max_geometry();
        set_frame(40, 3, 4, 30);       // rows wider than the random frames
        run_frame(1, 1'b0);
        set_frame(1, 24, 1, 0);        // a single tall column
        run_frame(3, 1'b0);
    endtask

    task automatic test_backpressure();
        set_frame(9, 7, 3, 12);
        fork
            begin
                hold_request = 1'b1;
                run_frame(1, 1'b0);
            end
        join
        // sender stops until every edge word is back, then continues
        set_frame(6, 6, 2, 8);
        run_frame(2, 1'b0);
    endtask

    task automatic test_random_frames();
        while (words_sent < 800) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            set_frame($urandom_range(1, 14), $urandom_range(1, 10),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 6),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 60));
            run_frame($urandom_range(0, 3), $urandom_range(0, 2) == 0);
        end
        burst_mode = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, one long hold-off when asked.
    // ------------------------------------------------------------------
    initial begin
        int p;
        forever begin
            @(posedge aclk);
            if (hold_request && aresetn) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end
            p = $urandom_range(0, 99);
            if (burst_mode || p < 70) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                if (p > 96) repeat ($urandom_range(5, 30)) @(posedge aclk);
            end
        end
    end

    // Check each edge word against the oldest prediction.
    always @(posedge aclk) begin
        edge_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (m_tdata[0]) edges_seen++;
            if (edge_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected edge word %h last %b", m_tdata, m_tlast);
            end else begin
                want = edge_queue.pop_front();
                if (m_tdata[0] !== want.edge_res || m_tdata[8:1] !== want.strength ||
                    m_tlast !== want.frame_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("edge word %0d: expected edge %b strength %0d end %b, got %b %0d %b",
                                 words_seen, want.edge_res, want.strength, want.frame_end,
                                 m_tdata[0], m_tdata[8:1], m_tlast);
                end
            end
        end
    end

    // Watchdog: nothing moving on either stream for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_registers();
        test_corner_frames();
        test_max_geometry();
        test_backpressure();
        test_random_frames();
        wait_drained();
        $display("covered %0d frames, %0d words in (%0d pixels), %0d edge words out, %0d edges",
                 frames_done, words_sent, pixels_sent, words_seen, edges_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/edp_pkg.sv
hw/rtl/edp_div.sv
hw/rtl/edp_core.sv
hw/rtl/edge_detect_pixel_stream_core.sv
hw/rtl/edp_checker.sv
tb/edge_detect_pixel_stream_core_tb.sv
